// ----- rtl/core/scsa_pkg.sv -----
`timescale 1ns / 1ps

package scsa_pkg;

    localparam int CLASS_COUNT = 4;
    localparam int MAX_SLOTS   = 1024;

    localparam int CLS_W   = $clog2(CLASS_COUNT);
    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int SIZE_W  = 25;
    localparam int REQ_W   = 32;
    localparam int HC_W    = 3;
    localparam int USED_W  = 35;
    localparam int TOTAL_W = 37;
    localparam int OFF_W   = 34;
    localparam int ADDR_W  = CLS_W + SLOT_W;
    localparam int STACK_DEPTH = CLASS_COUNT * MAX_SLOTS;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(32'd16777216);

    typedef enum logic [2:0] {
        REG_SIZE0  = 3'd0,
        REG_SIZE1  = 3'd1,
        REG_SIZE2  = 3'd2,
        REG_SIZE3  = 3'd3,
        REG_COUNT0 = 3'd4,
        REG_COUNT1 = 3'd5,
        REG_COUNT2 = 3'd6,
        REG_COUNT3 = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_BAD_HANDLE = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } t_ctrl_cmd;

    function automatic logic [SIZE_W-1:0] reset_size(input int c);
        reset_size = SIZE_W'(64) << (2 * c);
    endfunction

endpackage

// ----- rtl/core/scsa_ram.sv -----
`timescale 1ns / 1ps

module scsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/scsa_ctrl.sv -----
`timescale 1ns / 1ps

module scsa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output scsa_pkg::t_ctrl_cmd  o_cmd
);

    scsa_pkg::t_state r_state;
    scsa_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scsa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = scsa_pkg::S_EXEC;
                end
            end
            scsa_pkg::S_EXEC: begin
                n_state = scsa_pkg::S_DONE;
            end
            scsa_pkg::S_DONE: begin
                if (i_start) begin
                    n_state = scsa_pkg::S_EXEC;
                end else begin
                    n_state = scsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scsa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy       = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            scsa_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            scsa_pkg::S_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
            end
            scsa_pkg::S_DONE: begin
                o_cmd.load   = i_start;
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/scsa_datapath.sv -----
`timescale 1ns / 1ps

module scsa_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scsa_pkg::t_ctrl_cmd                 i_cmd,
    input  logic                                i_func,
    input  logic [scsa_pkg::REQ_W-1:0]          i_request_size,
    input  logic [scsa_pkg::HC_W-1:0]           i_handle_class,
    input  logic [scsa_pkg::SLOT_W-1:0]         i_handle_slot,
    input  logic                                i_cfg_we,
    input  logic [scsa_pkg::PADDR_W-1:0]        i_cfg_addr,
    input  logic [scsa_pkg::PDATA_W-1:0]        i_cfg_wdata,
    output logic [scsa_pkg::PDATA_W-1:0]        o_cfg_rdata,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic [scsa_pkg::CLS_W-1:0]          o_granted_class,
    output logic [scsa_pkg::SLOT_W-1:0]         o_granted_slot,
    output logic [scsa_pkg::OFF_W-1:0]          o_byte_offset,
    output logic [scsa_pkg::TOTAL_W-1:0]        o_bytes_in_use
);

    localparam int NC = scsa_pkg::CLASS_COUNT;

    // Per-class configuration and stack state.
    logic [scsa_pkg::SIZE_W-1:0] r_size  [NC];
    logic [scsa_pkg::CNT_W-1:0]  r_count [NC];
    logic [scsa_pkg::CNT_W-1:0]  r_depth [NC];
    logic [scsa_pkg::CNT_W-1:0]  r_low   [NC];
    logic [scsa_pkg::USED_W-1:0] r_used  [NC];
    logic [scsa_pkg::SIZE_W-1:0] n_size  [NC];
    logic [scsa_pkg::CNT_W-1:0]  n_count [NC];
    logic [scsa_pkg::CNT_W-1:0]  n_depth [NC];
    logic [scsa_pkg::CNT_W-1:0]  n_low   [NC];
    logic [scsa_pkg::USED_W-1:0] n_used  [NC];

    // Latched request.
    logic                        r_func;
    logic [scsa_pkg::REQ_W-1:0]  r_req;
    logic [scsa_pkg::HC_W-1:0]   r_hc;
    logic [scsa_pkg::SLOT_W-1:0] r_hs;

    // Results of the execute cycle.
    scsa_pkg::t_status           r_res_status;
    scsa_pkg::t_status           n_res_status;
    logic [scsa_pkg::CLS_W-1:0]  r_res_class;
    logic [scsa_pkg::CLS_W-1:0]  n_res_class;
    logic [scsa_pkg::SLOT_W-1:0] r_res_pos;
    logic [scsa_pkg::SLOT_W-1:0] n_res_pos;
    logic                        r_res_untouched;
    logic                        n_res_untouched;

    // Output registers.
    logic                         r_valid;
    logic [1:0]                   r_status;
    logic [scsa_pkg::CLS_W-1:0]   r_class;
    logic [scsa_pkg::SLOT_W-1:0]  r_slot;
    logic [scsa_pkg::OFF_W-1:0]   r_offset;
    logic [scsa_pkg::TOTAL_W-1:0] r_total;

    // Execute-cycle decisions.
    logic                        fit_found;
    logic [scsa_pkg::CLS_W-1:0]  fit_sel;
    logic [scsa_pkg::CNT_W-1:0]  pop_depth;
    logic [scsa_pkg::CLS_W-1:0]  hc_idx;
    logic                        hc_valid;
    logic                        free_bad;
    logic                        free_full;

    // Memory port.
    logic                        mem_en;
    logic                        mem_we;
    logic [scsa_pkg::ADDR_W-1:0] mem_addr;
    logic [scsa_pkg::SLOT_W-1:0] mem_rdata;

    // Configuration decode.
    scsa_pkg::t_reg_idx          cfg_idx;
    logic [scsa_pkg::CLS_W-1:0]  cfg_cls;
    logic [scsa_pkg::SIZE_W-1:0] cfg_size;
    logic [scsa_pkg::CNT_W-1:0]  cfg_count;
    logic [scsa_pkg::CNT_W-1:0]  cfg_used_slots;
    logic [scsa_pkg::CNT_W+scsa_pkg::SIZE_W-1:0] cfg_used_prod;

    // Finish-cycle datapath.
    logic [scsa_pkg::SLOT_W-1:0]  fin_slot;
    logic [scsa_pkg::SLOT_W+scsa_pkg::SIZE_W-1:0] fin_prod;
    logic [scsa_pkg::TOTAL_W-1:0] fin_total;

    assign cfg_idx = scsa_pkg::t_reg_idx'(i_cfg_addr[4:2]);
    assign cfg_cls = i_cfg_addr[2 +: scsa_pkg::CLS_W];

    always_comb begin
        cfg_size = i_cfg_wdata[scsa_pkg::SIZE_W-1:0];
        if (cfg_size == '0) begin
            cfg_size = scsa_pkg::SIZE_W'(1);
        end else if (cfg_size > scsa_pkg::SIZE_MAX) begin
            cfg_size = scsa_pkg::SIZE_MAX;
        end
        cfg_count = i_cfg_wdata[scsa_pkg::CNT_W-1:0];
        if (cfg_count > scsa_pkg::CNT_W'(scsa_pkg::MAX_SLOTS)) begin
            cfg_count = scsa_pkg::CNT_W'(scsa_pkg::MAX_SLOTS);
        end
    end

    assign cfg_used_slots = r_count[cfg_cls] - r_depth[cfg_cls];
    assign cfg_used_prod  = cfg_used_slots * cfg_size;

    always_comb begin
        o_cfg_rdata = '0;
        unique case (cfg_idx) inside
            [scsa_pkg::REG_SIZE0:scsa_pkg::REG_SIZE3]: begin
                o_cfg_rdata = scsa_pkg::PDATA_W'(r_size[cfg_cls]);
            end
            [scsa_pkg::REG_COUNT0:scsa_pkg::REG_COUNT3]: begin
                o_cfg_rdata = scsa_pkg::PDATA_W'(r_count[cfg_cls]);
            end
            default: begin
                o_cfg_rdata = '0;
            end
        endcase
    end

    // First class in ascending order that fits and has a free slot.
    always_comb begin
        fit_found = 1'b0;
        fit_sel   = '0;
        for (int c = 0; c < NC; c++) begin
            if (!fit_found && (r_depth[c] != '0) &&
                ({{(scsa_pkg::REQ_W-scsa_pkg::SIZE_W){1'b0}}, r_size[c]} >= r_req)) begin
                fit_found = 1'b1;
                fit_sel   = scsa_pkg::CLS_W'(c);
            end
        end
    end

    assign pop_depth = r_depth[fit_sel] - scsa_pkg::CNT_W'(1);
    assign hc_idx    = r_hc[scsa_pkg::CLS_W-1:0];
    assign hc_valid  = r_hc < scsa_pkg::HC_W'(NC);
    assign free_bad  = !hc_valid ||
                       ({1'b0, r_hs} >= r_count[hc_idx]);
    assign free_full = r_depth[hc_idx] >= r_count[hc_idx];

    always_comb begin
        mem_en   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = {fit_sel, pop_depth[scsa_pkg::SLOT_W-1:0]};
        if (i_cmd.exec) begin
            if (!r_func) begin
                mem_en = fit_found;
            end else if (!free_bad && !free_full) begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = {hc_idx, r_depth[hc_idx][scsa_pkg::SLOT_W-1:0]};
            end
        end
    end

    scsa_ram #(
        .WIDTH (scsa_pkg::SLOT_W),
        .DEPTH (scsa_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_hs),
        .o_rdata (mem_rdata)
    );

    // Entries below the low-water mark have not been rewritten since the
    // last refill, so they still hold their own index.
    always_comb begin
        n_size          = r_size;
        n_count         = r_count;
        n_depth         = r_depth;
        n_low           = r_low;
        n_used          = r_used;
        n_res_status    = r_res_status;
        n_res_class     = r_res_class;
        n_res_pos       = r_res_pos;
        n_res_untouched = r_res_untouched;
        if (i_cfg_we) begin
            unique case (cfg_idx) inside
                [scsa_pkg::REG_SIZE0:scsa_pkg::REG_SIZE3]: begin
                    n_size[cfg_cls] = cfg_size;
                    n_used[cfg_cls] = cfg_used_prod[scsa_pkg::USED_W-1:0];
                end
                [scsa_pkg::REG_COUNT0:scsa_pkg::REG_COUNT3]: begin
                    n_count[cfg_cls] = cfg_count;
                    n_depth[cfg_cls] = cfg_count;
                    n_low[cfg_cls]   = cfg_count;
                    n_used[cfg_cls]  = '0;
                end
                default: begin
                    n_used = r_used;
                end
            endcase
        end else if (i_cmd.exec) begin
            n_res_class     = '0;
            n_res_pos       = pop_depth[scsa_pkg::SLOT_W-1:0];
            n_res_untouched = pop_depth < r_low[fit_sel];
            if (!r_func) begin
                if (fit_found) begin
                    n_res_status     = scsa_pkg::ST_OK;
                    n_res_class      = fit_sel;
                    n_depth[fit_sel] = pop_depth;
                    if (pop_depth < r_low[fit_sel]) begin
                        n_low[fit_sel] = pop_depth;
                    end
                    n_used[fit_sel] = r_used[fit_sel] +
                                      scsa_pkg::USED_W'(r_size[fit_sel]);
                end else begin
                    n_res_status = scsa_pkg::ST_NO_FIT;
                end
            end else if (free_bad) begin
                n_res_status = scsa_pkg::ST_BAD_HANDLE;
            end else if (free_full) begin
                n_res_status = scsa_pkg::ST_FULL;
            end else begin
                n_res_status    = scsa_pkg::ST_OK;
                n_res_untouched = 1'b0;
                n_depth[hc_idx] = r_depth[hc_idx] + scsa_pkg::CNT_W'(1);
                n_used[hc_idx]  = r_used[hc_idx] -
                                  scsa_pkg::USED_W'(r_size[hc_idx]);
            end
        end
    end

    always_comb begin
        fin_slot = '0;
        if (r_res_status == scsa_pkg::ST_OK && !r_func) begin
            fin_slot = r_res_untouched ? r_res_pos : mem_rdata;
        end
        fin_total = '0;
        for (int c = 0; c < NC; c++) begin
            fin_total = fin_total + scsa_pkg::TOTAL_W'(r_used[c]);
        end
    end

    assign fin_prod = fin_slot * r_size[r_res_class];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NC; c++) begin
                r_size[c]  <= scsa_pkg::reset_size(c);
                r_count[c] <= '0;
                r_depth[c] <= '0;
                r_low[c]   <= '0;
                r_used[c]  <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            r_size  <= n_size;
            r_count <= n_count;
            r_depth <= n_depth;
            r_low   <= n_low;
            r_used  <= n_used;
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_req  <= i_request_size;
            r_hc   <= i_handle_class;
            r_hs   <= i_handle_slot;
        end
        r_res_status    <= n_res_status;
        r_res_class     <= n_res_class;
        r_res_pos       <= n_res_pos;
        r_res_untouched <= n_res_untouched;
        if (i_cmd.finish) begin
            r_status <= r_res_status;
            r_class  <= r_res_class;
            r_slot   <= fin_slot;
            r_offset <= fin_prod[scsa_pkg::OFF_W-1:0];
            r_total  <= fin_total;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_granted_class = r_class;
    assign o_granted_slot  = r_slot;
    assign o_byte_offset   = r_offset;
    assign o_bytes_in_use  = r_total;

endmodule

// ----- rtl/core/size_class_slab_allocator_top.sv -----
`timescale 1ns / 1ps

// Channel    Handshake                      Payload
// request    start in, busy out             i_func, i_request_size, i_handle_class,
//                                           i_handle_slot
// result     o_valid out, one cycle         o_status, o_granted_class, o_granted_slot,
//                                           o_byte_offset, o_bytes_in_use
// config     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A request is taken when start is high and busy is low; its result passes the
// execute and finish states and appears for one cycle. A new request may be taken
// in the finish state, before the result appears. Busy marks the execute state
// and its registered free-slot stack read. The receiver cannot stall the result.
// Reset is synchronous and needs no clearing pass: a per-class low-water mark
// tells which stack entries still hold their refill value.

module size_class_slab_allocator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [scsa_pkg::REQ_W-1:0]          i_request_size,
    input  logic [scsa_pkg::HC_W-1:0]           i_handle_class,
    input  logic [scsa_pkg::SLOT_W-1:0]         i_handle_slot,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic [scsa_pkg::CLS_W-1:0]          o_granted_class,
    output logic [scsa_pkg::SLOT_W-1:0]         o_granted_slot,
    output logic [scsa_pkg::OFF_W-1:0]          o_byte_offset,
    output logic [scsa_pkg::TOTAL_W-1:0]        o_bytes_in_use,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scsa_pkg::PADDR_W-1:0]        paddr,
    input  logic [scsa_pkg::PDATA_W-1:0]        pwdata,
    output logic [scsa_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    scsa_pkg::t_ctrl_cmd cmd;
    logic                cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    scsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    scsa_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_func),
        .i_request_size  (i_request_size),
        .i_handle_class  (i_handle_class),
        .i_handle_slot   (i_handle_slot),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (paddr),
        .i_cfg_wdata     (pwdata),
        .o_cfg_rdata     (prdata),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_granted_class (o_granted_class),
        .o_granted_slot  (o_granted_slot),
        .o_byte_offset   (o_byte_offset),
        .o_bytes_in_use  (o_bytes_in_use)
    );

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result missing three edges after a transfer");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result without a matching request transfer");

    a_failed_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != scsa_pkg::ST_OK) |->
            (o_granted_slot == '0 && o_byte_offset == '0 && o_granted_class == '0))
        else $error("failed request returned a slot");

endmodule
